// ===== hdl/htw_pkg.sv =====
package htw_pkg;

    localparam int TASK_W    = 16;
    localparam int DELAY_W   = 24;
    localparam int TIME_W    = 32;
    localparam int PERIOD_W  = 10;
    localparam int NSLOT_W   = 8;
    localparam int ELAPSED_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;
    localparam logic [NSLOT_W-1:0]  NSLOT_RESET  = 8'd100;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 24'hFFFFFF;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        ST_EXPIRED  = 1'b0,
        ST_REJECTED = 1'b1
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_PERIOD = 1'b0,
        CFG_SLOT_COUNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_SEND
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ROW,
        B_REJ,
        B_SCAN,
        B_CHK,
        B_END
    } t_back_state;

    // classified request handed from front to back
    typedef struct packed {
        t_op                 op;
        logic [TASK_W-1:0]   task_id;
        logic [DELAY_W-1:0]  delay;
        logic                wants;
        logic [NSLOT_W-1:0]  qmod;
    } t_cmd;

    typedef struct packed {
        t_status               status;
        logic [TASK_W-1:0]     task_id;
        logic [ELAPSED_W-1:0]  elapsed;
        logic                  last;
    } t_res;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  insert_time;
        logic [TASK_W-1:0]  task_id;
        logic               wants;
    } t_entry;

endpackage

// ===== hdl/htw_fifo.sv =====
module htw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== hdl/htw_front.sv =====
module htw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  htw_pkg::t_op                   i_op,
    input  logic [htw_pkg::TASK_W-1:0]     i_task_id,
    input  logic [htw_pkg::DELAY_W-1:0]    i_delay,
    input  logic                           i_wants,
    output logic                           o_busy,
    input  logic [htw_pkg::PERIOD_W-1:0]   i_period,
    input  logic [htw_pkg::NSLOT_W-1:0]    i_nslots,
    output logic                           o_cmd_push,
    output htw_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_full
);
    import htw_pkg::*;

    localparam int CNT_W = $clog2(DELAY_W);

    t_front_state          r_state;
    t_front_state          n_state;
    t_cmd                  r_cmd;
    logic [DELAY_W-1:0]    r_dvd;
    logic [PERIOD_W-1:0]   r_rem;
    logic [NSLOT_W-1:0]    r_qm;
    logic [CNT_W-1:0]      r_cnt;

    logic [PERIOD_W:0]     trial;
    logic                  qbit;
    logic [PERIOD_W-1:0]   n_rem;
    logic [NSLOT_W:0]      q2;
    logic [NSLOT_W-1:0]    n_qm;

    // one quotient bit per cycle, quotient kept modulo slot count
    always_comb begin
        trial = {r_rem, r_dvd[DELAY_W-1]};
        qbit  = (trial >= {1'b0, i_period});
        n_rem = qbit ? PERIOD_W'(trial - {1'b0, i_period}) : PERIOD_W'(trial);
        q2    = {r_qm, qbit};
        n_qm  = (q2 >= {1'b0, i_nslots}) ? NSLOT_W'(q2 - {1'b0, i_nslots})
                                         : NSLOT_W'(q2);
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_push = 1'b0;
        o_cmd      = r_cmd;
        o_cmd.qmod = r_qm;
        unique case (r_state)
            F_IDLE: begin
                if (i_take) begin
                    n_state = (i_op == OP_ADD) ? F_DIV : F_SEND;
                end
            end
            F_DIV: begin
                if (r_cnt == CNT_W'(DELAY_W-1)) begin
                    n_state = F_SEND;
                end
            end
            F_SEND: begin
                if (!i_cmd_full) begin
                    o_cmd_push = 1'b1;
                    n_state    = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_busy = (r_state != F_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_take) begin
            r_cmd.op      <= i_op;
            r_cmd.task_id <= i_task_id;
            r_cmd.delay   <= i_delay;
            r_cmd.wants   <= i_wants;
            r_cmd.qmod    <= '0;
            r_dvd         <= i_delay;
            r_rem         <= '0;
            r_qm          <= '0;
            r_cnt         <= '0;
        end else if (r_state == F_DIV) begin
            r_dvd <= {r_dvd[DELAY_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_qm  <= n_qm;
            r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule

// ===== hdl/htw_back.sv =====
module htw_back #(
    parameter int NUM_SLOTS     = 128,
    parameter int SLOT_CAPACITY = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  htw_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_empty,
    output logic                           o_cmd_pop,
    input  logic [htw_pkg::PERIOD_W-1:0]   i_period,
    input  logic [htw_pkg::NSLOT_W-1:0]    i_nslots,
    output logic                           o_res_push,
    output htw_pkg::t_res                  o_res,
    input  logic                           i_res_full,
    output logic                           o_clearing
);
    import htw_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int ENTRIES = NUM_SLOTS * SLOT_CAPACITY;
    localparam int EW = $clog2(ENTRIES);
    localparam int CW = ((SW > NSLOT_W) ? SW : NSLOT_W) + 1;

    logic [SLOT_CAPACITY-1:0] r_vmem [NUM_SLOTS];
    t_entry                   r_emem [ENTRIES];

    t_back_state              r_state;
    t_back_state              n_state;
    t_cmd                     r_cmd;
    logic [TIME_W-1:0]        r_ct;
    logic [SW-1:0]            r_pos;
    logic [SW-1:0]            r_slot;
    logic [SW-1:0]            r_clr;
    logic [KW-1:0]            r_k;
    logic [SLOT_CAPACITY-1:0] r_row;
    logic [SLOT_CAPACITY-1:0] r_vrow;
    t_entry                   r_ent;
    t_res                     r_held;
    logic                     r_held_v;

    logic [CW-1:0]            pos_use;
    logic [CW-1:0]            n_ext;
    logic [CW-1:0]            sum;
    logic [CW-1:0]            slot_add;
    logic [CW-1:0]            slot_sel;
    logic [CW-1:0]            pos_inc;
    logic [CW-1:0]            pos_next;

    logic                     vwr_en;
    logic [SW-1:0]            vwr_addr;
    logic [SLOT_CAPACITY-1:0] vwr_data;
    logic                     vrd_en;
    logic                     ewr_en;
    logic                     erd_en;
    logic [EW-1:0]            base;
    logic [EW-1:0]            ewr_addr;
    logic [EW-1:0]            erd_addr;
    t_entry                   ewr_data;

    logic                     free_found;
    logic [KW-1:0]            free_idx;
    logic [TIME_W-1:0]        age;
    logic [TIME_W-1:0]        slack;
    logic                     expired;
    t_res                     cand;
    logic                     k_last;
    logic                     chk_go;

    // slot arithmetic on the head request
    always_comb begin
        n_ext    = CW'(i_nslots);
        pos_use  = (CW'(r_pos) < n_ext) ? CW'(r_pos) : '0;
        sum      = CW'(i_cmd.qmod) + pos_use;
        slot_add = (sum >= n_ext) ? sum - n_ext : sum;
        slot_sel = (i_cmd.op == OP_ADD) ? slot_add : pos_use;
        pos_inc  = pos_use + 1'b1;
        pos_next = (pos_inc >= n_ext) ? '0 : pos_inc;
    end

    // first free entry of the slot row
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_CAPACITY - 1; i >= 0; i--) begin
            if (!r_vrow[i]) begin
                free_found = 1'b1;
                free_idx   = KW'(i);
            end
        end
    end

    always_comb begin
        base    = EW'(r_slot) * EW'(SLOT_CAPACITY);
        slack   = r_ct - r_ent.deadline;
        expired = !slack[TIME_W-1];
        age     = r_ct - r_ent.insert_time;
        cand.status  = ST_EXPIRED;
        cand.task_id = r_ent.task_id;
        cand.last    = 1'b0;
        if (!r_ent.wants) begin
            cand.elapsed = '0;
        end else if (|age[TIME_W-1:ELAPSED_W]) begin
            cand.elapsed = ELAPSED_MAX;
        end else begin
            cand.elapsed = age[ELAPSED_W-1:0];
        end
        k_last   = (r_k == KW'(SLOT_CAPACITY-1));
        chk_go   = !(expired && r_held_v && i_res_full);
        ewr_data.deadline    = r_ct + TIME_W'(r_cmd.delay);
        ewr_data.insert_time = r_ct;
        ewr_data.task_id     = r_cmd.task_id;
        ewr_data.wants       = r_cmd.wants;
        ewr_addr = base + EW'(free_idx);
        erd_addr = base + EW'(r_k);
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_held;
        vwr_en     = 1'b0;
        vwr_addr   = r_slot;
        vwr_data   = r_row;
        vrd_en     = 1'b0;
        ewr_en     = 1'b0;
        erd_en     = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                vwr_en   = 1'b1;
                vwr_addr = r_clr;
                vwr_data = '0;
                if (r_clr == SW'(NUM_SLOTS-1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    vrd_en    = 1'b1;
                    n_state   = B_ROW;
                end
            end
            B_ROW: begin
                if (r_cmd.op == OP_TICK) begin
                    n_state = B_SCAN;
                end else if (free_found) begin
                    vwr_en   = 1'b1;
                    vwr_data = r_vrow | (SLOT_CAPACITY'(1) << free_idx);
                    ewr_en   = 1'b1;
                    n_state  = B_IDLE;
                end else begin
                    n_state = B_REJ;
                end
            end
            B_REJ: begin
                o_res.status  = ST_REJECTED;
                o_res.task_id = r_cmd.task_id;
                o_res.elapsed = '0;
                o_res.last    = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            B_SCAN: begin
                if (r_row[r_k]) begin
                    erd_en  = 1'b1;
                    n_state = B_CHK;
                end else if (k_last) begin
                    n_state = B_END;
                end
            end
            B_CHK: begin
                if (chk_go) begin
                    o_res_push = expired && r_held_v;
                    n_state    = k_last ? B_END : B_SCAN;
                end
            end
            B_END: begin
                o_res.last = 1'b1;
                if (!(r_held_v && i_res_full)) begin
                    o_res_push = r_held_v;
                    vwr_en     = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_clearing = (r_state == B_CLEAR);

    always_ff @(posedge i_clk) begin
        if (vwr_en) begin
            r_vmem[vwr_addr] <= vwr_data;
        end
        if (vrd_en) begin
            r_vrow <= r_vmem[SW'(slot_sel)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ewr_en) begin
            r_emem[ewr_addr] <= ewr_data;
        end
        if (erd_en) begin
            r_ent <= r_emem[erd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_ct     <= '0;
            r_pos    <= '0;
            r_held_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == B_IDLE && !i_cmd_empty && i_cmd.op == OP_TICK) begin
                r_ct  <= r_ct + TIME_W'(i_period);
                r_pos <= SW'(pos_next);
            end
            if (r_state == B_CHK && chk_go && expired) begin
                r_held_v <= 1'b1;
            end else if (r_state == B_END && n_state == B_IDLE) begin
                r_held_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && !i_cmd_empty) begin
            r_cmd  <= i_cmd;
            r_slot <= SW'(slot_sel);
        end
        if (r_state == B_ROW) begin
            r_row <= r_vrow;
            r_k   <= '0;
        end else if (r_state == B_SCAN && !r_row[r_k] && !k_last) begin
            r_k <= r_k + 1'b1;
        end else if (r_state == B_CHK && chk_go) begin
            if (expired) begin
                r_row[r_k] <= 1'b0;
                r_held     <= cand;
            end
            if (!k_last) begin
                r_k <= r_k + 1'b1;
            end
        end
    end
endmodule

// ===== hdl/hashed_timing_wheel.sv =====
// hashed timing wheel: one-shot tasks hashed into slots, expired on ticks
// add: a 24-step divide in the front, then the valid-row read and entry write in the back;
// tick: a scan of the occupied entries of the current slot, results follow as scanned;
// the front takes no new request until it has handed the last one to the queue
// reset: synchronous active low; the back then clears NUM_SLOTS valid rows,
// one a cycle, with full held high until the pass is done
module hashed_timing_wheel #(
    parameter int NUM_SLOTS     = 128,
    parameter int SLOT_CAPACITY = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request side
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [htw_pkg::TASK_W-1:0]        i_task_id,
    input  logic [htw_pkg::DELAY_W-1:0]       i_delay_ms,
    input  logic                              i_wants_elapsed,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_status,
    output logic [htw_pkg::TASK_W-1:0]        o_task_id_out,
    output logic [htw_pkg::ELAPSED_W-1:0]     o_elapsed_ms,
    output logic                              o_last_of_run,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [htw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [htw_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import htw_pkg::*;

    localparam logic [10:0] NS_MAX = 11'(NUM_SLOTS);

    logic [PERIOD_W-1:0] r_tick_period;
    logic [NSLOT_W-1:0]  r_slot_count;
    logic [PERIOD_W-1:0] period_use;
    logic [NSLOT_W-1:0]  nslots_use;

    logic   front_busy;
    logic   clearing;
    logic   take;
    logic   cmd_push;
    t_cmd   cmd_in;
    logic   cmd_full;
    t_cmd   cmd_out;
    logic   cmd_empty;
    logic   cmd_pop;
    logic   res_push;
    t_res   res_in;
    logic   res_full;
    t_res   res_out;

    // config writes land at once; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= PERIOD_RESET;
            r_slot_count  <= NSLOT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TICK_PERIOD) begin
                r_tick_period <= i_cfg_data[PERIOD_W-1:0];
            end else if (i_cfg_index == CFG_SLOT_COUNT) begin
                r_slot_count <= i_cfg_data[NSLOT_W-1:0];
            end
        end
    end

    // zero period counts as one; slot count clamped to 1..NUM_SLOTS
    always_comb begin
        period_use = (r_tick_period == '0) ? PERIOD_W'(1) : r_tick_period;
        if (r_slot_count == '0) begin
            nslots_use = NSLOT_W'(1);
        end else if (11'(r_slot_count) > NS_MAX) begin
            nslots_use = NSLOT_W'(NS_MAX);
        end else begin
            nslots_use = r_slot_count;
        end
    end

    // no request taken while the front divides or hands on, or the valid rows clear
    assign full = front_busy || clearing;
    assign take = push && !full;

    htw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_op       (t_op'(i_operation)),
        .i_task_id  (i_task_id),
        .i_delay    (i_delay_ms),
        .i_wants    (i_wants_elapsed),
        .o_busy     (front_busy),
        .i_period   (period_use),
        .i_nslots   (nslots_use),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // short queue decoupling classification from slot work
    htw_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    htw_back #(
        .NUM_SLOTS     (NUM_SLOTS),
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_period    (period_use),
        .i_nslots    (nslots_use),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full),
        .o_clearing  (clearing)
    );

    // result queue, lets the back keep scanning while the consumer stalls, until it fills
    htw_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_status      = res_out.status;
    assign o_task_id_out = res_out.task_id;
    assign o_elapsed_ms  = res_out.elapsed;
    assign o_last_of_run = res_out.last;
endmodule

// ===== tb/sv/hashed_timing_wheel_test.sv =====
`timescale 1ns / 1ps

module hashed_timing_wheel_test;
    import htw_pkg::*;

    localparam int NUM_SLOTS     = 128;
    localparam int SLOT_CAPACITY = 8;
    localparam int ENTRY_COUNT   = NUM_SLOTS * SLOT_CAPACITY;
    // settle time covers an add and a full slot scan, and up to
    // four requests can still be in flight once every report is in
    localparam int SETTLE_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 300000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic                 i_operation;
    logic [TASK_W-1:0]    i_task_id;
    logic [DELAY_W-1:0]   i_delay_ms;
    logic                 i_wants_elapsed;
    logic                 empty;
    logic                 pop;
    logic                 o_status;
    logic [TASK_W-1:0]    o_task_id_out;
    logic [ELAPSED_W-1:0] o_elapsed_ms;
    logic                 o_last_of_run;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    hashed_timing_wheel #(
        .NUM_SLOTS    (NUM_SLOTS),
        .SLOT_CAPACITY(SLOT_CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_task_id      (i_task_id),
        .i_delay_ms     (i_delay_ms),
        .i_wants_elapsed(i_wants_elapsed),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_task_id_out  (o_task_id_out),
        .o_elapsed_ms   (o_elapsed_ms),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // shadow copy of the wheel
    logic [PERIOD_W-1:0] shadow_period;
    logic [NSLOT_W-1:0]  shadow_slots;
    logic [TIME_W-1:0]   now_ms;
    int unsigned         wheel_pos;
    bit                  slot_used   [ENTRY_COUNT];
    logic [TIME_W-1:0]   due_ms      [ENTRY_COUNT];
    logic [TIME_W-1:0]   added_ms    [ENTRY_COUNT];
    logic [TASK_W-1:0]   owner_task  [ENTRY_COUNT];
    bit                  report_age  [ENTRY_COUNT];

    t_res pending_reports[$];
    int   mismatch_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    longint cycle_count;

    // directed rows: exp_count < 0 means the shadow wheel decides
    typedef struct {
        t_op                op;
        logic [TASK_W-1:0]  task_id;
        logic [DELAY_W-1:0] delay;
        logic               wants;
        int                 exp_count;
        t_status            exp_status;
        logic [TASK_W-1:0]  exp_task;
    } t_row;

    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned slots_now();
        if (shadow_slots == 0) return 1;
        if (shadow_slots > NUM_SLOTS) return NUM_SLOTS;
        return shadow_slots;
    endfunction

    function automatic int unsigned period_now();
        return (shadow_period == 0) ? 1 : shadow_period;
    endfunction

    // advance the shadow wheel by one accepted request, queue what it reports
    task automatic predict_wheel(input t_op op, input logic [TASK_W-1:0] id,
                                 input logic [DELAY_W-1:0] delay, input logic wants,
                                 output t_res reports[$]);
        int unsigned n;
        int unsigned pos;
        int unsigned slot;
        int unsigned e;
        logic [TIME_W-1:0] age;
        t_res r;
        reports = {};
        n = slots_now();
        pos = (wheel_pos < n) ? wheel_pos : 0;
        if (op == OP_ADD) begin
            slot = ((delay / period_now()) % n + pos) % n;
            for (int k = 0; k < SLOT_CAPACITY; k++) begin
                e = slot * SLOT_CAPACITY + k;
                if (!slot_used[e]) begin
                    slot_used[e]  = 1'b1;
                    due_ms[e]     = now_ms + delay;
                    added_ms[e]   = now_ms;
                    owner_task[e] = id;
                    report_age[e] = wants;
                    return;
                end
            end
            r = '{status: ST_REJECTED, task_id: id, elapsed: '0, last: 1'b1};
            reports.insert(reports.size(), r);
            return;
        end
        now_ms = now_ms + period_now();
        for (int k = 0; k < SLOT_CAPACITY; k++) begin
            e = pos * SLOT_CAPACITY + k;
            age = now_ms - due_ms[e];
            if (slot_used[e] && !age[TIME_W-1]) begin
                age = now_ms - added_ms[e];
                r.status  = ST_EXPIRED;
                r.task_id = owner_task[e];
                r.elapsed = !report_age[e] ? '0 :
                            (age > ELAPSED_MAX) ? ELAPSED_MAX : age[ELAPSED_W-1:0];
                r.last    = 1'b0;
                reports.insert(reports.size(), r);
                slot_used[e] = 1'b0;
            end
        end
        if (reports.size() > 0) reports[reports.size()-1].last = 1'b1;
        wheel_pos = (pos + 1 >= n) ? 0 : pos + 1;
    endtask

    // hand one request to the block, then record what it should report
    task automatic send_request(input t_row row);
        t_res reports[$];
        t_res fixed;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_operation     <= row.op;
        i_task_id       <= row.task_id;
        i_delay_ms      <= row.delay;
        i_wants_elapsed <= row.wants;
        do @(posedge i_clk); while (full);
        predict_wheel(row.op, row.task_id, row.delay, row.wants, reports);
        if (row.exp_count == 0) begin
            reports = {};
        end else if (row.exp_count == 1) begin
            fixed = '{status: row.exp_status, task_id: row.exp_task,
                      elapsed: '0, last: 1'b1};
            reports = {};
            reports.insert(0, fixed);
        end
        foreach (reports[i]) pending_reports.insert(pending_reports.size(), reports[i]);
    endtask

    // block must be idle: all reports in and any silent request finished
    task automatic wait_until_idle();
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TICK_PERIOD) shadow_period = value;
        else                        shadow_slots  = value[NSLOT_W-1:0];
    endtask

    task automatic set_wheel(input logic [CFG_DAT_W-1:0] period,
                             input logic [CFG_DAT_W-1:0] slots);
        wait_until_idle();
        write_register(CFG_TICK_PERIOD, period);
        write_register(CFG_SLOT_COUNT, slots);
    endtask

    // result side: compare each popped report with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected report: task %h status %b", o_task_id_out,
                                 o_status);
                end else begin
                    t_res want;
                    want = pending_reports.pop_front();
                    if (o_status !== want.status || o_task_id_out !== want.task_id ||
                        o_elapsed_ms !== want.elapsed || o_last_of_run !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %b %h %0d %b, got %b %h %0d %b",
                                     want.status, want.task_id, want.elapsed, want.last,
                                     o_status, o_task_id_out, o_elapsed_ms, o_last_of_run);
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic t_row make_row(input t_op op, input int id, input int delay,
                                      input bit wants, input int exp_count = -1,
                                      input t_status exp_status = ST_EXPIRED,
                                      input int exp_task = 0);
        t_row row;
        row.op = op; row.task_id = TASK_W'(id); row.delay = DELAY_W'(delay);
        row.wants = wants;
        row.exp_count = exp_count; row.exp_status = exp_status;
        row.exp_task = TASK_W'(exp_task);
        return row;
    endfunction

    function automatic t_row random_row();
        int unsigned span;
        logic [DELAY_W-1:0] delay;
        span = period_now() * slots_now() * 3;
        if ($urandom_range(0, 9) < 7) delay = DELAY_W'($urandom_range(0, span));
        else                          delay = DELAY_W'($urandom());
        return make_row($urandom_range(0, 1) ? OP_TICK : OP_ADD, $urandom(), delay,
                        $urandom_range(0, 1));
    endfunction

    initial begin
        int idle_modes [4][2] = '{'{0, 0}, '{77, 0}, '{0, 77}, '{7, 7}};
        int wheel_setups [4][2] = '{'{7, 128}, '{1, 3}, '{0, 0}, '{1023, 255}};

        cycle_count     = 0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_operation     = 1'b0;
        i_task_id       = '0;
        i_delay_ms      = '0;
        i_wants_elapsed = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        shadow_period   = PERIOD_RESET;
        shadow_slots    = NSLOT_RESET;
        now_ms          = '0;
        wheel_pos       = 0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty tick, fill one slot, overflow it, drain it
        directed_rows.insert(directed_rows.size(), make_row(OP_TICK, 0, 0, 0, 0));
        for (int i = 1; i <= SLOT_CAPACITY; i++)
            directed_rows.insert(directed_rows.size(), make_row(OP_ADD, i, 0, i % 2));
        directed_rows.insert(directed_rows.size(),
                             make_row(OP_ADD, 16'hFFFF, 5, 1, 1, ST_REJECTED, 16'hFFFF));
        directed_rows.insert(directed_rows.size(), make_row(OP_TICK, 0, 0, 0));
        directed_rows.insert(directed_rows.size(), make_row(OP_ADD, 0, 24'hFFFFFF, 1));
        directed_rows.insert(directed_rows.size(), make_row(OP_ADD, 16'h1234, 9, 0));
        directed_rows.insert(directed_rows.size(),
                             make_row(OP_TICK, 16'hFFFF, 24'hFFFFFF, 1));
        directed_rows.insert(directed_rows.size(), make_row(OP_ADD, 16'hABCD, 25, 1));
        for (int i = 0; i < 4; i++)
            directed_rows.insert(directed_rows.size(), make_row(OP_TICK, 0, 0, 0));
        foreach (directed_rows[i]) send_request(directed_rows[i]);

        // random phases; a large slot count followed by a small one
        // leaves the position beyond the slots in use
        for (int ph = 0; ph < 4; ph++) begin
            set_wheel(CFG_DAT_W'(wheel_setups[ph][0]), CFG_DAT_W'(wheel_setups[ph][1]));
            send_idle_pct  = idle_modes[ph][0];
            recv_stall_pct = idle_modes[ph][1];
            for (int i = 0; i < 66; i++) send_request(random_row());
        end

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
